[rtl/isr_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// isr_pkg
// Shared widths and pipeline types for the integer square root unit.
// ----------------------------------------------------------------------------
package isr_pkg;

	// radicand and root widths
	localparam int RADICAND_W = 32;
	localparam int ROOT_W     = 16;

	// one result bit per pipeline stage
	localparam int STEPS = (RADICAND_W + 1) / 2;
	localparam int PAD_W = 2 * STEPS;
	localparam int REM_W = STEPS + 2;

	// largest root that fits the root port
	localparam logic [ROOT_W-1:0] MAX_ROOT = {ROOT_W{1'b1}};

	// data carried by one item between stages
	typedef struct packed {
		logic [PAD_W-1:0] rad;
		logic [REM_W-1:0] rem;
		logic [STEPS-1:0] root;
	} isr_pipe_t;

endpackage
`default_nettype wire

[rtl/isr_stage.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// isr_stage
// One digit step of the restoring square root: brings in the next two
// radicand bits, tries to set the next root bit and registers the result.
// ----------------------------------------------------------------------------
module isr_stage import isr_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	input  wire isr_pipe_t in_data,
	output logic           out_valid,
	output isr_pipe_t      out_data
);

	logic              stage_valid_s1;
	isr_pipe_t         stage_data_s1;
	logic [REM_W+1:0]  rem_shift;
	logic [REM_W+1:0]  trial;
	logic              take;
	isr_pipe_t         next_data;

	// shift in two radicand bits and compare against 4*root + 1
	always_comb begin
		rem_shift      = {in_data.rem, in_data.rad[PAD_W-1 -: 2]};
		trial          = {2'b00, in_data.root, 2'b01};
		take           = (rem_shift >= trial);
		next_data.rad  = {in_data.rad[PAD_W-3:0], 2'b00};
		next_data.rem  = take ? REM_W'(rem_shift - trial) : REM_W'(rem_shift);
		next_data.root = {in_data.root[STEPS-2:0], take};
	end

	// valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_valid_s1 <= 1'b0;
		end else begin
			stage_valid_s1 <= in_valid;
		end
	end

	// payload register
	always_ff @(posedge clk) begin
		if (in_valid) begin
			stage_data_s1 <= next_data;
		end
	end

	assign out_valid = stage_valid_s1;
	assign out_data  = stage_data_s1;

endmodule
`default_nettype wire

[rtl/integer_square_root_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// integer_square_root_unit
// Floor of the square root of a 32-bit unsigned radicand, one result bit per
// pipeline stage.
// ----------------------------------------------------------------------------
// result: done is the registered valid bit of the last of the 16 digit stages
// throughput: one item per cycle, busy stays low; set by the 16-stage digit pipe
// the receiver cannot stall, so every item moves one stage per cycle
// reset: arst_n clears all stage valid bits; no item is in flight afterwards
module integer_square_root_unit import isr_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	output logic                       busy,
	input  wire logic [RADICAND_W-1:0] radicand,
	output logic                       done,
	output logic [ROOT_W-1:0]          root
);

	logic      pipe_valid [0:STEPS];
	isr_pipe_t pipe_data  [0:STEPS];

	// the pipe always moves, so new items are always taken
	assign busy = 1'b0;

	// stage entry: padded radicand, empty remainder and root
	assign pipe_valid[0]     = start & ~busy;
	assign pipe_data[0].rad  = PAD_W'(radicand);
	assign pipe_data[0].rem  = '0;
	assign pipe_data[0].root = '0;

	// digit pipeline
	for (genvar i = 0; i < STEPS; i++) begin : g_stage
		isr_stage u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (pipe_valid[i]),
			.in_data   (pipe_data[i]),
			.out_valid (pipe_valid[i+1]),
			.out_data  (pipe_data[i+1])
		);
	end

	// result
	assign done = pipe_valid[STEPS];
	assign root = ROOT_W'(pipe_data[STEPS].root);

	// a result always follows an accepted item that has passed through the whole pipe
	a_done_follows_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, STEPS))
		else $error("done without a matching accepted item");

	// zero radicand yields zero root
	a_zero_root: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && radicand == '0) |-> ##STEPS (done && root == '0))
		else $error("zero radicand gave nonzero root");

	// all-ones radicand yields the largest root
	a_max_root: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && radicand == {RADICAND_W{1'b1}}) |-> ##STEPS
		(done && root == MAX_ROOT))
		else $error("full-scale radicand gave wrong root");

endmodule
`default_nettype wire

[tb/sv/isr_checker.sv]
// ----------------------------------------------------------------------------
// isr_checker
// Watches the item and result channels of the integer square root unit,
// works out the floor root of every accepted radicand by Newton iteration
// and compares each done strobe with the oldest outstanding root.
// ----------------------------------------------------------------------------
module isr_checker import isr_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic                  busy,
	input  logic [RADICAND_W-1:0] radicand,
	input  logic                  done,
	input  logic [ROOT_W-1:0]     root,
	output int                    mismatch_count,
	output int                    roots_pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [RADICAND_W-1:0] radicand;
		logic [ROOT_W-1:0]     root;
	} root_entry_t;

	root_entry_t expected_roots[$];

	// floor square root by newton steps from a power-of-two guess
	function automatic logic [ROOT_W-1:0] newton_floor_root(input logic [RADICAND_W-1:0] x);
		logic [63:0] xv;
		logic [63:0] v;
		logic [63:0] g_prev;
		logic [63:0] g_next;
		int          s;
		xv = 64'(x);
		if (xv <= 64'd1)
			return ROOT_W'(xv);
		// starting exponent from the bit length of x - 1
		v = xv - 64'd1;
		s = 1;
		if (v > 64'hFFFF_FFFF) begin s += 16; v >>= 32; end
		if (v > 64'hFFFF)      begin s += 8;  v >>= 16; end
		if (v > 64'hFF)        begin s += 4;  v >>= 8;  end
		if (v > 64'hF)         begin s += 2;  v >>= 4;  end
		if (v > 64'h3)         begin s += 1;            end
		g_prev = 64'd1 << s;
		g_next = (g_prev + (xv >> s)) >> 1;
		// keep stepping while the estimate shrinks
		while (g_next < g_prev) begin
			g_prev = g_next;
			if (g_prev == 64'd0)
				break;
			g_next = (g_prev + xv / g_prev) >> 1;
		end
		return g_prev[ROOT_W-1:0];
	endfunction

	// predict on accepted items, compare on done strobes
	always @(posedge clk) begin
		root_entry_t entry;
		int          fails;
		fails = mismatch_count;
		if (arst_n) begin
			if (done) begin
				if (expected_roots.size() == 0) begin
					if (fails < 10)
						$display("unexpected root %0d with no item outstanding", root);
					fails++;
				end else begin
					entry = expected_roots.pop_front();
					if (root !== entry.root) begin
						if (fails < 10)
							$display("root mismatch for radicand %0d: expected %0d, got %0d",
								entry.radicand, entry.root, root);
						fails++;
					end
				end
			end
			if (start && !busy) begin
				entry.radicand = radicand;
				entry.root     = newton_floor_root(radicand);
				expected_roots.push_back(entry);
			end
		end
		mismatch_count <= fails;
		roots_pending  <= expected_roots.size();
	end

endmodule

[tb/sv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Drives radicands into the integer square root unit: a directed set of edge
// values, then random radicands with bursts of idle cycles, and reports the
// verdict from the checker's mismatch count.
// ----------------------------------------------------------------------------
module tb_top import isr_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_ITEMS = 1100;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  start = 1'b0;
	logic [RADICAND_W-1:0] radicand = '0;
	logic                  busy;
	logic                  done;
	logic [ROOT_W-1:0]     root;
	int                    mismatch_count;
	int                    roots_pending;

	integer_square_root_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.radicand (radicand),
		.done     (done),
		.root     (root)
	);

	isr_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.radicand       (radicand),
		.done           (done),
		.root           (root),
		.mismatch_count (mismatch_count),
		.roots_pending  (roots_pending)
	);

	// clock
	always #5 clk = ~clk;

	// hard stop
	initial begin
		#2_000_000;
		$display("tb_top failed");
		$finish;
	end

	// idle for gap cycles, then hold one item until the unit takes it
	task automatic send_item(input logic [RADICAND_W-1:0] x, input int gap);
		repeat (gap) begin
			@(negedge clk);
			start    <= 1'b0;
			radicand <= $urandom;
		end
		@(negedge clk);
		start    <= 1'b1;
		radicand <= x;
		do
			@(posedge clk);
		while (busy);
	endtask

	// random radicand: full range, near perfect squares, short bit lengths
	function automatic logic [RADICAND_W-1:0] random_radicand();
		logic [31:0] r;
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: begin
				r = $urandom_range(0, 65535);
				return r * r + 32'($urandom_range(0, 2)) - 32'd1;
			end
			2: return $urandom >> $urandom_range(0, 31);
			default: return $urandom_range(0, 1023);
		endcase
	endfunction

	// stimulus and verdict
	initial begin
		logic [RADICAND_W-1:0] edge_values[$];
		int                    gap;
		edge_values = {32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd8, 32'd15, 32'd16,
			32'd17, 32'd24, 32'd25, 32'd99, 32'd100, 32'h0000_FFFF, 32'h0001_0000,
			32'h3FFF_FFFF, 32'h4000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
			32'hFFFE_0000, 32'hFFFE_0001, 32'hFFFF_FFFE, 32'hFFFF_FFFF};

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed edge values, back to back
		foreach (edge_values[i])
			send_item(edge_values[i], 0);

		// random radicands with idle bursts, calm stretches and a calm tail
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == RANDOM_ITEMS / 2) begin
				// drain everything before going on
				@(negedge clk);
				start <= 1'b0;
				while (roots_pending != 0)
					@(posedge clk);
			end
			if (i >= RANDOM_ITEMS - 150 || (i / 100) % 3 == 2)
				gap = 0;
			else
				gap = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 15) : 0;
			send_item(random_radicand(), gap);
		end
		@(negedge clk);
		start <= 1'b0;

		// drain and let the pipe settle
		while (roots_pending != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		if (mismatch_count == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule
